>>> rtl/core/bkh_pkg.sv
// Shared types and constants of the bounded k-best max-heap unit.
package bkh_pkg;

  localparam int CAP_W   = 6;
  localparam int COUNT_W = 6;
  localparam int VAL_W   = 32;

  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0] index;
    logic [VAL_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VAL_W-1:0]   worst;
    logic               entry_valid;
    entry_t             entry;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/bounded_k_best_max_heap_unit.sv
// Top level of the bounded k-best max-heap unit: capacity register and stream ports.
//
//   channel  direction  carries
//   s_axis   in         tuser: operation; tdata: candidate index, distance
//   m_axis   out        tdata: count, worst, entry index, distance; tuser: valid
//   cfg      in         heap capacity, written when cfg_we is high
//
// An append walks up one heap level per parent read, compare and write back; a
// root replacement walks down one level per step, both children read at once.
// An insert puts its result on m_axis when its walk ends, and the next beat is
// taken once the unit is back in idle. Clear goes straight to its result;
// read-out sends one beat per kept entry, the last one marked with last.
// Reset empties the heap and sets the capacity to one; memory is not cleared.
// A new beat is taken while the previous result still waits on m_axis.
module bounded_k_best_max_heap_unit import bkh_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // candidate_index, candidate_distance
  input  logic [1:0]           s_axis_tuser,  // operation
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [103:0]         m_axis_tdata,  // entry_count, worst_distance,
                                              // entry_index, entry_distance, zero pad
  output logic                 m_axis_tuser,  // entry_valid
  output logic                 m_axis_tlast,  // last
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);

  logic [CAP_W-1:0] capacity;
  entry_t           in_entry;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  entry_t           wr_data, rd_data_a, rd_data_b;
  out_beat_t        out_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(1);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign in_entry.index    = s_axis_tdata[31:0];
  assign in_entry.distance = s_axis_tdata[63:32];

  bkh_store #(
    .DEPTH (MAX_K),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bkh_ctrl #(
    .MAX_K (MAX_K),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser)),
    .in_entry  (in_entry),
    .mem_ctl   (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_beat  (out_beat)
  );

  assign m_axis_tdata = {2'b00, out_beat.entry.distance, out_beat.entry.index,
                         out_beat.worst, out_beat.count};
  assign m_axis_tuser = out_beat.entry_valid;
  assign m_axis_tlast = out_beat.last;

endmodule

>>> rtl/core/bkh_store.sv
// Heap storage: one write port and two registered read ports.
module bkh_store import bkh_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data_a,
  output entry_t        rd_data_b
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> rtl/core/bkh_ctrl.sv
// Heap sequencer: sift up, sift down, read-out and the result register.
module bkh_ctrl import bkh_pkg::*; #(
  parameter int MAX_K = 32,
  parameter int AW    = 5,
  parameter int CW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             in_valid,
  output logic             in_ready,
  input  op_t              in_op,
  input  entry_t           in_entry,
  output mem_ctl_t         mem_ctl,
  output logic [AW-1:0]    rd_addr_a,
  output logic [AW-1:0]    rd_addr_b,
  output logic [AW-1:0]    wr_addr,
  output entry_t           wr_data,
  input  entry_t           rd_data_a,
  input  entry_t           rd_data_b,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_beat
);

  localparam int LW = AW + 2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_DN_RD  = 8'b0000_1000,
    S_DN_CMP = 8'b0001_0000,
    S_RO_RD  = 8'b0010_0000,
    S_RO_OUT = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     pos, pos_next;
  logic [AW-1:0]     ro_idx, ro_idx_next;
  logic [CW-1:0]     held, held_next;
  entry_t            item, item_next;
  logic [VAL_W-1:0]  root_dist;
  logic              out_valid_next;
  out_beat_t         out_beat_next;

  logic [CW-1:0]     k_eff;
  logic              can_append;
  logic              slot_free;
  logic [VAL_W-1:0]  worst;
  logic [AW-1:0]     parent;
  logic [LW-1:0]     left, right;
  logic              left_ok, right_ok;
  logic              ro_last;
  logic              take_left, take_right;

  // Capacity zero counts as one, anything above MAX_K saturates.
  always_comb begin
    if ({2'b00, capacity} > 8'(MAX_K)) begin
      k_eff = CW'(MAX_K);
    end else if (capacity == '0) begin
      k_eff = CW'(1);
    end else begin
      k_eff = CW'(capacity);
    end
  end

  assign can_append = (held < k_eff) && (held < CW'(MAX_K));
  assign worst      = (held < k_eff) ? ALL_ONES : root_dist;
  assign slot_free  = !out_valid || out_ready;
  assign parent     = (pos - AW'(1)) >> 1;
  assign left       = {1'b0, pos, 1'b1};
  assign right      = LW'({1'b0, pos, 1'b0}) + LW'(2);
  assign left_ok    = left < LW'(held);
  assign right_ok   = right < LW'(held);
  assign ro_last    = (LW'(ro_idx) + LW'(1)) == LW'(held);

  // The larger child wins; a child only moves up when strictly larger.
  assign take_left  = rd_data_a.distance > item.distance;
  assign take_right = right_ok &&
                      (rd_data_b.distance >
                       (take_left ? rd_data_a.distance : item.distance));

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    ro_idx_next    = ro_idx;
    held_next      = held;
    item_next      = item;
    out_valid_next = out_valid && !out_ready;
    out_beat_next  = out_beat;
    mem_ctl        = '0;
    rd_addr_a      = '0;
    rd_addr_b      = '0;
    wr_addr        = pos;
    wr_data        = item;
    in_ready       = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next = in_entry;
          case (in_op)
            OP_INSERT: begin
              if (can_append) begin
                pos_next   = AW'(held);
                held_next  = held + CW'(1);
                state_next = S_UP_RD;
              end else if (held != '0 && in_entry.distance < root_dist) begin
                pos_next   = '0;
                state_next = S_DN_RD;
              end else begin
                state_next = S_RESP;
              end
            end
            OP_CLEAR: begin
              held_next  = '0;
              state_next = S_RESP;
            end
            OP_READ: begin
              ro_idx_next = '0;
              state_next  = (held == '0) ? S_RESP : S_RO_RD;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          mem_ctl.wr_en = 1'b1;
          state_next    = S_RESP;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = parent;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if (item.distance > rd_data_a.distance) begin
          wr_data    = rd_data_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_DN_RD: begin
        if (!left_ok) begin
          mem_ctl.wr_en = 1'b1;
          state_next    = S_RESP;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = left[AW-1:0];
          rd_addr_b     = right_ok ? right[AW-1:0] : left[AW-1:0];
          state_next    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if (take_right) begin
          wr_data    = rd_data_b;
          pos_next   = right[AW-1:0];
          state_next = S_DN_RD;
        end else if (take_left) begin
          wr_data    = rd_data_a;
          pos_next   = left[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RO_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr_a     = ro_idx;
        state_next    = S_RO_OUT;
      end
      S_RO_OUT: begin
        if (slot_free) begin
          out_valid_next            = 1'b1;
          out_beat_next.count       = COUNT_W'(held);
          out_beat_next.worst       = worst;
          out_beat_next.entry_valid = 1'b1;
          out_beat_next.entry       = rd_data_a;
          out_beat_next.last        = ro_last;
          if (ro_last) begin
            state_next = S_IDLE;
          end else begin
            ro_idx_next = ro_idx + AW'(1);
            state_next  = S_RO_RD;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_next            = 1'b1;
          out_beat_next.count       = COUNT_W'(held);
          out_beat_next.worst       = worst;
          out_beat_next.entry_valid = 1'b0;
          out_beat_next.entry       = '0;
          out_beat_next.last        = 1'b1;
          state_next                = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
    pos      <= pos_next;
    ro_idx   <= ro_idx_next;
    item     <= item_next;
    out_beat <= out_beat_next;
    // Shadow of the root distance, kept in step with every write to slot zero.
    if (mem_ctl.wr_en && wr_addr == '0) begin
      root_dist <= wr_data.distance;
    end
  end

endmodule
